/* rtl/sse_pkg.sv */
package sse_pkg;

  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_SEARCH = 3'd3;
  localparam logic [2:0] CMD_EDIT   = 3'd4;
  localparam logic [2:0] CMD_DELETE = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic signed [31:0] new_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped;
    logic [7:0]         match_mask;
    logic               found;
    logic [3:0]         level;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       push;
    logic       clear;
    logic       rd;
    logic       chk;
    logic       pop;
    logic       emit;
    logic [1:0] status;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       empty;
    logic       full;
    logic       last;
  } sts_t;

endpackage

/* rtl/searchable_stack_engine.sv */
// Searchable LIFO stack of signed 32-bit words, DEPTH entries deep.
// Request channel: start with in_req (cmd, value, new_value); a request
// is taken at a clock edge where start is high and busy is low. busy stays
// high until the result has been produced.
// Result channel: out_valid strobes for exactly one cycle with out_res
// (status, popped, match_mask, found, level). There is no backpressure;
// the receiver must take the result in that cycle.
// Push, clear, refused and unused commands are finished in S_DECODE; pop
// reads the top entry there and completes in S_POP; search/edit/delete
// walk the entries. A new request can be taken the cycle the strobe shows.
// Each walked entry takes a registered memory read (S_READ) and then a
// compare/write-back (S_CHECK).
// Synchronous active-low reset empties the stack and drops busy and
// out_valid; stack contents are not cleared.
module searchable_stack_engine #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sse_pkg::in_t  in_req,
  output logic          out_valid,
  output sse_pkg::out_t out_res
);

  sse_pkg::ctl_t ctl;
  sse_pkg::sts_t sts;

  sse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  sse_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

/* rtl/sse_ctrl.sv */
module sse_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sse_pkg::sts_t sts,
  output sse_pkg::ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_CHECK,
    S_POP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  assign busy = busy_r;

  always_comb begin
    ctl       = '0;
    ctl.status = sse_pkg::ST_DONE;
    state_nxt = state_r;
    busy_nxt  = busy_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECODE;
          busy_nxt  = 1'b1;
        end
      end
      S_DECODE: begin
        priority if (sts.cmd == sse_pkg::CMD_PUSH) begin
          if (sts.full) begin
            ctl.status = sse_pkg::ST_FULL;
          end else begin
            ctl.push = 1'b1;
          end
          ctl.emit = 1'b1;
        end else if (sts.cmd > sse_pkg::CMD_DELETE) begin
          ctl.emit = 1'b1;
        end else if (sts.empty) begin
          ctl.status = sse_pkg::ST_EMPTY;
          ctl.emit   = 1'b1;
        end else if (sts.cmd == sse_pkg::CMD_POP) begin
          ctl.rd    = 1'b1;
          state_nxt = S_POP;
        end else if (sts.cmd == sse_pkg::CMD_CLEAR) begin
          ctl.clear = 1'b1;
          ctl.emit  = 1'b1;
        end else begin
          state_nxt = S_READ;
        end
        if (ctl.emit) begin
          state_nxt = S_IDLE;
          busy_nxt  = 1'b0;
        end
      end
      S_READ: begin
        ctl.rd    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        ctl.chk = 1'b1;
        if (sts.last) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
          busy_nxt  = 1'b0;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_POP: begin
        ctl.pop   = 1'b1;
        ctl.emit  = 1'b1;
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> busy_r)
    else $error("busy not raised after request load");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> !busy_r)
    else $error("busy still high after result");

  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != S_IDLE))
    else $error("busy disagrees with state");

endmodule

/* rtl/sse_dpath.sv */
module sse_dpath #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sse_pkg::in_t  in_req,
  input  sse_pkg::ctl_t ctl,
  output sse_pkg::sts_t sts,
  output logic          out_valid,
  output sse_pkg::out_t out_res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic signed [31:0] mem [DEPTH];

  logic [2:0]         cmd_r;
  logic signed [31:0] key_r;
  logic signed [31:0] nval_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic signed [31:0] rd_i_r, rd_t_r;
  logic signed [31:0] popped_r, popped_nxt;
  logic [7:0]         mask_r, mask_nxt;
  logic               found_r, found_nxt;
  logic               out_valid_r;
  sse_pkg::out_t      out_r;

  logic [CW-1:0]      cnt_m1, idx_inc;
  logic [CW-1:0]      cnt_chk;
  logic [CW+7:0]      idx_x;
  logic [CW+3:0]      lvl_x;
  logic               match;
  logic               we;
  logic [AW-1:0]      wa;
  logic signed [31:0] wd;

  assign cnt_m1  = cnt_r - CW'(1);
  assign idx_inc = idx_r + CW'(1);
  assign idx_x   = (CW + 8)'(idx_r);
  assign lvl_x   = (CW + 4)'(cnt_nxt);
  assign match   = (rd_i_r == key_r);
  assign cnt_chk = (match && cmd_r == sse_pkg::CMD_DELETE) ? cnt_m1 : cnt_r;

  always_comb begin
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    popped_nxt = popped_r;
    mask_nxt   = mask_r;
    found_nxt  = found_r;
    we         = 1'b0;
    wa         = idx_r[AW-1:0];
    wd         = nval_r;
    if (ctl.load) begin
      idx_nxt    = '0;
      popped_nxt = '0;
      mask_nxt   = '0;
      found_nxt  = 1'b0;
    end
    if (ctl.push) begin
      we      = 1'b1;
      wa      = cnt_r[AW-1:0];
      wd      = key_r;
      cnt_nxt = cnt_r + CW'(1);
    end
    if (ctl.clear) begin
      cnt_nxt = '0;
    end
    if (ctl.pop) begin
      popped_nxt = rd_t_r;
      cnt_nxt    = cnt_m1;
    end
    if (ctl.chk) begin
      idx_nxt = idx_inc;
      if (match) begin
        found_nxt = 1'b1;
        if (idx_x < (CW + 8)'(8)) begin
          mask_nxt[idx_x[2:0]] = 1'b1;
        end
        if (cmd_r == sse_pkg::CMD_EDIT) begin
          we = 1'b1;
        end else if (cmd_r == sse_pkg::CMD_DELETE) begin
          we      = 1'b1;
          wd      = rd_t_r;
          cnt_nxt = cnt_m1;
        end
      end
    end
  end

  always_comb begin
    sts.cmd   = cmd_r;
    sts.empty = (cnt_r == '0);
    sts.full  = (cnt_r == CW'(DEPTH));
    sts.last  = (idx_inc >= cnt_chk);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctl.rd) begin
      rd_i_r <= mem[idx_r[AW-1:0]];
      rd_t_r <= mem[cnt_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_req.cmd;
      key_r  <= in_req.value;
      nval_r <= in_req.new_value;
    end
    idx_r    <= idx_nxt;
    popped_r <= popped_nxt;
    mask_r   <= mask_nxt;
    found_r  <= found_nxt;
    if (ctl.emit) begin
      out_r.status     <= ctl.status;
      out_r.popped     <= popped_nxt;
      out_r.match_mask <= mask_nxt;
      out_r.found      <= found_nxt;
      out_r.level      <= lvl_x[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= ctl.emit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd |-> (cnt_r != '0))
    else $error("memory read on empty stack");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("back-to-back result strobes");

endmodule

/* tb/searchable_stack_checker.sv */
`timescale 1ns / 1ps
module searchable_stack_checker #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  sse_pkg::in_t  in_req,
  input  logic          out_valid,
  input  sse_pkg::out_t out_res,
  output int            mismatches,
  output int            pending
);

  logic [31:0]   stack_words [DEPTH];
  int unsigned   stack_fill;
  sse_pkg::out_t expected_results [$];
  sse_pkg::out_t want;
  sse_pkg::out_t predicted;

  initial begin
    mismatches = 0;
    pending    = 0;
    stack_fill = 0;
  end

  // one request against the local copy of the stack
  task automatic execute_request(input sse_pkg::in_t req, output sse_pkg::out_t res);
    int unsigned i;
    res = '0;
    res.status = sse_pkg::ST_DONE;
    case (req.cmd)
      sse_pkg::CMD_PUSH: begin
        if (stack_fill >= DEPTH) begin
          res.status = sse_pkg::ST_FULL;
        end else begin
          stack_words[stack_fill] = req.value;
          stack_fill++;
        end
      end
      sse_pkg::CMD_POP, sse_pkg::CMD_CLEAR, sse_pkg::CMD_SEARCH, sse_pkg::CMD_EDIT,
      sse_pkg::CMD_DELETE: begin
        if (stack_fill == 0) begin
          res.status = sse_pkg::ST_EMPTY;
        end else if (req.cmd == sse_pkg::CMD_POP) begin
          stack_fill--;
          res.popped = stack_words[stack_fill];
        end else if (req.cmd == sse_pkg::CMD_CLEAR) begin
          stack_fill = 0;
        end else begin
          // delete: match takes the top word, which is not compared again
          i = 0;
          while (i < stack_fill) begin
            if (stack_words[i] == req.value) begin
              if (i < 8) res.match_mask[i] = 1'b1;
              res.found = 1'b1;
              if (req.cmd == sse_pkg::CMD_EDIT) begin
                stack_words[i] = req.new_value;
              end else if (req.cmd == sse_pkg::CMD_DELETE) begin
                stack_words[i] = stack_words[stack_fill - 1];
                stack_fill--;
              end
            end
            i++;
          end
        end
      end
      default: ;
    endcase
    res.level = 4'(stack_fill);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stack_fill = 0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d popped %h mask %h",
                     out_res.status, out_res.popped, out_res.match_mask,
                     " found %0d level %0d", out_res.found, out_res.level);
        end else begin
          want = expected_results.pop_front();
          if (out_res.status !== want.status || out_res.popped !== want.popped ||
              out_res.match_mask !== want.match_mask || out_res.found !== want.found ||
              out_res.level !== want.level) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st %0d pop %h mask %h fnd %0d lvl %0d,",
                       want.status, want.popped, want.match_mask, want.found,
                       want.level,
                       " got st %0d pop %h mask %h fnd %0d lvl %0d",
                       out_res.status, out_res.popped, out_res.match_mask,
                       out_res.found, out_res.level);
          end
        end
      end
      if (start && !busy) begin
        execute_request(in_req, predicted);
        expected_results.push_back(predicted);
      end
    end
    pending = expected_results.size();
  end

endmodule

/* tb/searchable_stack_engine_tb.sv */
`timescale 1ns / 1ps
module searchable_stack_engine_tb;

  localparam int DEPTH = 8;
  localparam int RANDOM_REQUESTS = 700;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  sse_pkg::in_t  in_req;
  logic          out_valid;
  sse_pkg::out_t out_res;
  int            mismatches;
  int            pending;
  int            cycle_count;
  bit            idle_ok;
  logic [31:0]   key_pool [4];

  searchable_stack_engine #(.DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  searchable_stack_checker #(.DEPTH(DEPTH)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // request held until taken at an edge with busy low
  task automatic issue(input logic [2:0] cmd, input logic [31:0] value,
                       input logic [31:0] new_value);
    sse_pkg::in_t req;
    req.cmd       = cmd;
    req.value     = value;
    req.new_value = new_value;
    while (idle_ok && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_req        <= req;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    if ($urandom_range(99) < 70) return key_pool[$urandom_range(3)];
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_command();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 38) return sse_pkg::CMD_PUSH;
    if (r < 50) return sse_pkg::CMD_POP;
    if (r < 53) return sse_pkg::CMD_CLEAR;
    if (r < 68) return sse_pkg::CMD_SEARCH;
    if (r < 81) return sse_pkg::CMD_EDIT;
    if (r < 95) return sse_pkg::CMD_DELETE;
    return ($urandom_range(1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
  endfunction

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_req  = '0;
    idle_ok = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack and spare codes
    issue(sse_pkg::CMD_POP, 32'h0, 32'h0);
    issue(sse_pkg::CMD_CLEAR, 32'h0, 32'h0);
    issue(sse_pkg::CMD_SEARCH, 32'h0, 32'h0);
    issue(sse_pkg::CMD_EDIT, 32'h0, 32'h1);
    issue(sse_pkg::CMD_DELETE, 32'h0, 32'h0);
    issue(CMD_SPARE_LO, 32'hffff_ffff, 32'hffff_ffff);
    // fill to full with extremes and repeated keys
    issue(sse_pkg::CMD_PUSH, 32'h8000_0000, 32'h0);
    issue(sse_pkg::CMD_PUSH, 32'h7fff_ffff, 32'h0);
    issue(sse_pkg::CMD_PUSH, 32'h0000_0000, 32'h0);
    issue(sse_pkg::CMD_PUSH, 32'hffff_ffff, 32'h0);
    issue(sse_pkg::CMD_PUSH, 32'h0000_0007, 32'h0);
    issue(sse_pkg::CMD_PUSH, 32'h0000_0007, 32'h0);
    issue(sse_pkg::CMD_PUSH, 32'h7fff_ffff, 32'h0);
    issue(sse_pkg::CMD_PUSH, 32'h0000_0007, 32'h0);
    issue(sse_pkg::CMD_PUSH, 32'h0000_0005, 32'h0);
    issue(CMD_SPARE_HI, 32'h0, 32'h0);
    issue(sse_pkg::CMD_SEARCH, 32'h0000_0007, 32'h0);
    issue(sse_pkg::CMD_EDIT, 32'h7fff_ffff, 32'h0000_0007);
    // top word matches, moved words skipped
    issue(sse_pkg::CMD_DELETE, 32'h0000_0007, 32'h0);
    issue(sse_pkg::CMD_SEARCH, 32'h0000_0007, 32'h0);
    issue(sse_pkg::CMD_POP, 32'h0, 32'h0);
    issue(sse_pkg::CMD_DELETE, 32'h8000_0000, 32'h0);
    issue(sse_pkg::CMD_EDIT, 32'h1234_5678, 32'h8000_0000);
    issue(sse_pkg::CMD_CLEAR, 32'h0, 32'h0);
    issue(sse_pkg::CMD_SEARCH, 32'hffff_ffff, 32'h0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0)
        foreach (key_pool[k]) key_pool[k] = $urandom;
      idle_ok = !(n >= 250 && n < 400);
      issue(pick_command(), pick_word(), pick_word());
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
